>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define ASSERT_AFTER(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("latency check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_AFTER(label, clk, rst_n, a, n, b)
`endif
`endif

>>> sv/miru_pkg.sv
// Package with types and constants of the ravel/unravel unit.
`default_nettype none
package miru_pkg;
    localparam int MAX_DIMS_DEF = 4;
    localparam int NUM_SLOTS = 4;
    localparam int COORD_BITS = 16;
    localparam logic [15:0] COORD_MASK = 16'((64'd1 << COORD_BITS) - 64'd1);
    localparam int RADIX_BITS = 4;
    localparam int DIV_STAGES = 64 / RADIX_BITS;

    localparam logic [2:0] REG_NUM_DIMS = 3'd0;
    localparam logic [2:0] REG_DIM_0 = 3'd1;
    localparam logic [2:0] REG_DIM_1 = 3'd2;
    localparam logic [2:0] REG_DIM_2 = 3'd3;
    localparam logic [2:0] REG_DIM_3 = 3'd4;

    typedef struct packed {
        logic        func;
        logic [63:0] flat_in;
        logic [15:0] coord_in_0;
        logic [15:0] coord_in_1;
        logic [15:0] coord_in_2;
        logic [15:0] coord_in_3;
    } item_t;

    typedef struct packed {
        logic [63:0] flat_out;
        logic [15:0] coord_out_0;
        logic [15:0] coord_out_1;
        logic [15:0] coord_out_2;
        logic [15:0] coord_out_3;
    } result_t;

    typedef struct packed {
        logic [2:0]       nd;
        logic [3:0][15:0] size;
    } cfg_t;

    typedef struct packed {
        logic             func;
        logic [63:0]      acc;
        logic [15:0]      rem;
        logic [47:0]      pl;
        logic [47:0]      ph;
        logic [3:0][15:0] cin;
        logic [3:0][15:0] cout;
    } pipe_t;
endpackage
`default_nettype wire

>>> sv/miru_slot.sv
// One dimension step: multiply-add for ravel, radix-16 divide for unravel.
`default_nettype none
module miru_slot #(
    parameter int SLOT = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire miru_pkg::cfg_t   cfg,
    input  wire logic             in_valid,
    input  wire miru_pkg::pipe_t  in_data,
    output logic                  out_valid,
    output miru_pkg::pipe_t       out_data
);
    localparam int STAGES = miru_pkg::DIV_STAGES;

    logic            valid_reg [STAGES];
    miru_pkg::pipe_t data_reg  [STAGES];
    logic            valid_cur [STAGES+1];
    miru_pkg::pipe_t data_cur  [STAGES+1];
    miru_pkg::pipe_t data_next [STAGES];

    logic        act;
    logic [1:0]  uidx;
    logic [15:0] udiv;
    logic [15:0] rsize;

    assign act   = 3'(SLOT) < cfg.nd;
    assign uidx  = 2'(cfg.nd - 3'd1 - 3'(SLOT));
    assign udiv  = cfg.size[uidx];
    assign rsize = cfg.size[SLOT];

    assign valid_cur[0] = in_valid;
    assign data_cur[0]  = in_data;

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        assign valid_cur[j+1] = valid_reg[j];
        assign data_cur[j+1]  = data_reg[j];

        always_comb
        begin
            miru_pkg::pipe_t p;
            logic [16:0]     r;
            p = data_cur[j];
            r = '0;
            if (act) begin
                if (!p.func) begin
                    if (j == 0) begin
                        p.pl = 48'(p.acc[31:0]) * 48'(rsize);
                        p.ph = 48'(p.acc[63:32]) * 48'(rsize);
                    end else if (j == 1) begin
                        p.acc = {p.ph[31:0], 32'd0} + {16'd0, p.pl}
                                + {48'd0, p.cin[SLOT]};
                    end
                end else if (udiv != 16'd0) begin
                    for (int b = 0; b < miru_pkg::RADIX_BITS; b++) begin
                        r = {p.rem, p.acc[63]};
                        p.acc = {p.acc[62:0], 1'b0};
                        if (r >= {1'b0, udiv}) begin
                            r = r - {1'b0, udiv};
                            p.acc[0] = 1'b1;
                        end
                        p.rem = r[15:0];
                    end
                    if (j == STAGES - 1) begin
                        p.cout[uidx] = p.rem;
                        p.rem = '0;
                    end
                end
            end
            data_next[j] = p;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[j] <= 1'b0;
            end else begin
                valid_reg[j] <= valid_cur[j];
            end
        end

        always_ff @(posedge clk)
        begin
            data_reg[j] <= data_next[j];
        end
    end

    assign out_valid = valid_cur[STAGES];
    assign out_data  = data_cur[STAGES];
endmodule
`default_nettype wire

>>> sv/multi_index_ravel_unravel.sv
// Top level of the row-major ravel/unravel unit with its register port.
// From start to done an item passes the input register, each slot's divider stages and the done register.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Each dimension step is 16 stages of a radix-16 divider, four quotient bits each.
// Reset clears the valid bits; registers reset to num_dims 1 and all sizes 1.
`default_nettype none
`include "assert_macros.svh"
module multi_index_ravel_unravel #(
    parameter int MAX_DIMS = miru_pkg::MAX_DIMS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire miru_pkg::item_t   item,
    output logic                   done,
    output miru_pkg::result_t      result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int DIM_LIMIT = (MAX_DIMS < miru_pkg::NUM_SLOTS) ? MAX_DIMS
                                                                : miru_pkg::NUM_SLOTS;
    localparam int LATENCY = miru_pkg::DIV_STAGES * DIM_LIMIT + 2;

    logic [2:0]       num_dims_reg;
    logic [3:0][15:0] dim_size_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;
    miru_pkg::cfg_t   cfg;

    logic              in_valid_reg;
    miru_pkg::pipe_t   in_data_reg;
    miru_pkg::pipe_t   in_data_next;
    logic              slot_valid [DIM_LIMIT+1];
    miru_pkg::pipe_t   slot_data  [DIM_LIMIT+1];
    logic              done_reg;
    miru_pkg::result_t result_reg;
    miru_pkg::result_t result_next;
    miru_pkg::pipe_t   last;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            num_dims_reg <= 3'd1;
            dim_size_reg <= {4{16'd1}};
        end else if (wr_en) begin
            unique case (reg_idx)
                miru_pkg::REG_NUM_DIMS: num_dims_reg    <= pwdata[2:0];
                miru_pkg::REG_DIM_0:    dim_size_reg[0] <= pwdata[15:0] & miru_pkg::COORD_MASK;
                miru_pkg::REG_DIM_1:    dim_size_reg[1] <= pwdata[15:0] & miru_pkg::COORD_MASK;
                miru_pkg::REG_DIM_2:    dim_size_reg[2] <= pwdata[15:0] & miru_pkg::COORD_MASK;
                miru_pkg::REG_DIM_3:    dim_size_reg[3] <= pwdata[15:0] & miru_pkg::COORD_MASK;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            miru_pkg::REG_NUM_DIMS: prdata = {29'd0, num_dims_reg};
            miru_pkg::REG_DIM_0:    prdata = {16'd0, dim_size_reg[0]};
            miru_pkg::REG_DIM_1:    prdata = {16'd0, dim_size_reg[1]};
            miru_pkg::REG_DIM_2:    prdata = {16'd0, dim_size_reg[2]};
            miru_pkg::REG_DIM_3:    prdata = {16'd0, dim_size_reg[3]};
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.size = dim_size_reg;
        if (num_dims_reg == 3'd0) begin
            cfg.nd = 3'd1;
        end else if (num_dims_reg > 3'(DIM_LIMIT)) begin
            cfg.nd = 3'(DIM_LIMIT);
        end else begin
            cfg.nd = num_dims_reg;
        end
    end

    always_comb
    begin
        in_data_next.func    = item.func;
        in_data_next.acc     = item.func ? item.flat_in : 64'd0;
        in_data_next.rem     = '0;
        in_data_next.pl      = '0;
        in_data_next.ph      = '0;
        in_data_next.cin[0]  = item.coord_in_0 & miru_pkg::COORD_MASK;
        in_data_next.cin[1]  = item.coord_in_1 & miru_pkg::COORD_MASK;
        in_data_next.cin[2]  = item.coord_in_2 & miru_pkg::COORD_MASK;
        in_data_next.cin[3]  = item.coord_in_3 & miru_pkg::COORD_MASK;
        in_data_next.cout    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            in_valid_reg <= start && !busy;
            done_reg     <= slot_valid[DIM_LIMIT];
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
        result_reg  <= result_next;
    end

    assign slot_valid[0] = in_valid_reg;
    assign slot_data[0]  = in_data_reg;

    for (genvar k = 0; k < DIM_LIMIT; k++) begin : g_slot
        miru_slot #(
            .SLOT (k)
        ) u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .in_valid  (slot_valid[k]),
            .in_data   (slot_data[k]),
            .out_valid (slot_valid[k+1]),
            .out_data  (slot_data[k+1])
        );
    end

    assign last = slot_data[DIM_LIMIT];

    always_comb
    begin
        result_next.flat_out    = last.func ? 64'd0 : last.acc;
        result_next.coord_out_0 = last.cout[0];
        result_next.coord_out_1 = last.cout[1];
        result_next.coord_out_2 = last.cout[2];
        result_next.coord_out_3 = last.cout[3];
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_AFTER(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    `ASSERT_IMPLIES(a_one_kind, clk, rst_n, done && (result.flat_out != 64'd0), (result.coord_out_0 == 16'd0) && (result.coord_out_1 == 16'd0) && (result.coord_out_2 == 16'd0) && (result.coord_out_3 == 16'd0))
    `ASSERT_IMPLIES(a_one_dim, clk, rst_n, done && (cfg.nd == 3'd1), (result.coord_out_1 == 16'd0) && (result.coord_out_2 == 16'd0) && (result.coord_out_3 == 16'd0))
endmodule
`default_nettype wire

>>> sim/tb_multi_index_ravel_unravel.sv
// Testbench of the ravel/unravel unit: directed table, then random items against a predictor.
`default_nettype none
module tb_multi_index_ravel_unravel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 16 * 4 + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    miru_pkg::item_t item = '0;
    logic done;
    miru_pkg::result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    multi_index_ravel_unravel u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    typedef struct {
        miru_pkg::item_t   stim;
        logic              known;
        miru_pkg::result_t want;
    } row_t;

    logic [2:0] shape_dims;
    logic [15:0] shape_size [4];
    miru_pkg::result_t pending_results [$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;

    function automatic miru_pkg::result_t convert_index(miru_pkg::item_t it);
        miru_pkg::result_t r;
        int nd;
        logic [63:0] acc;
        logic [15:0] c [4];
        logic [15:0] o [4];
        c = '{it.coord_in_0, it.coord_in_1, it.coord_in_2, it.coord_in_3};
        o = '{16'd0, 16'd0, 16'd0, 16'd0};
        r = '0;
        nd = (shape_dims == 3'd0) ? 1 : (shape_dims > 3'd4 ? 4 : int'(shape_dims));
        if (it.func == 1'b0)
        begin
            acc = '0;
            for (int d = 0; d < nd; d++)
                acc = acc * {48'd0, shape_size[d]} + {48'd0, c[d]};
            r.flat_out = acc;
        end
        else
        begin
            acc = it.flat_in;
            for (int d = nd - 1; d >= 0; d--)
                if (shape_size[d] != 16'd0)
                begin
                    o[d] = 16'(acc % {48'd0, shape_size[d]});
                    acc = acc / {48'd0, shape_size[d]};
                end
            r.coord_out_0 = o[0];
            r.coord_out_1 = o[1];
            r.coord_out_2 = o[2];
            r.coord_out_3 = o[3];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        miru_pkg::result_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result.flat_out, 64'd0);
            else
            begin
                w = pending_results.pop_front();
                if (result.flat_out !== w.flat_out)
                    report_mismatch("flat_out", result.flat_out, w.flat_out);
                if (result.coord_out_0 !== w.coord_out_0)
                    report_mismatch("coord_out_0", 64'(result.coord_out_0),
                                    64'(w.coord_out_0));
                if (result.coord_out_1 !== w.coord_out_1)
                    report_mismatch("coord_out_1", 64'(result.coord_out_1),
                                    64'(w.coord_out_1));
                if (result.coord_out_2 !== w.coord_out_2)
                    report_mismatch("coord_out_2", 64'(result.coord_out_2),
                                    64'(w.coord_out_2));
                if (result.coord_out_3 !== w.coord_out_3)
                    report_mismatch("coord_out_3", 64'(result.coord_out_3),
                                    64'(w.coord_out_3));
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == miru_pkg::REG_NUM_DIMS)
            shape_dims = value[2:0];
        else if (idx <= miru_pkg::REG_DIM_3)
            shape_size[idx - 1] = value[15:0];
        @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_shape(logic [2:0] nd, logic [15:0] s0, logic [15:0] s1,
                             logic [15:0] s2, logic [15:0] s3);
        drain_results();
        write_reg(miru_pkg::REG_NUM_DIMS, {29'd0, nd});
        write_reg(miru_pkg::REG_DIM_0, {16'd0, s0});
        write_reg(miru_pkg::REG_DIM_1, {16'd0, s1});
        write_reg(miru_pkg::REG_DIM_2, {16'd0, s2});
        write_reg(miru_pkg::REG_DIM_3, {16'd0, s3});
    endtask

    task automatic send_item(miru_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results = {pending_results, convert_index(it)};
    endtask

    function automatic miru_pkg::item_t random_item();
        miru_pkg::item_t it;
        int pick;
        it.func = 1'($urandom_range(1));
        pick = $urandom_range(3);
        it.flat_in = {$urandom, $urandom};
        if (pick == 0)
            it.flat_in = it.flat_in >> $urandom_range(63);
        else if (pick == 1)
            it.flat_in = 64'($urandom_range(4095));
        it.coord_in_0 = 16'($urandom);
        it.coord_in_1 = 16'($urandom);
        it.coord_in_2 = 16'($urandom);
        it.coord_in_3 = 16'($urandom);
        if ($urandom_range(1))
        begin
            it.coord_in_0 = 16'(it.coord_in_0 % (shape_size[0] + 17'd1));
            it.coord_in_1 = 16'(it.coord_in_1 % (shape_size[1] + 17'd1));
            it.coord_in_2 = 16'(it.coord_in_2 % (shape_size[2] + 17'd1));
            it.coord_in_3 = 16'(it.coord_in_3 % (shape_size[3] + 17'd1));
        end
        return it;
    endfunction

    task automatic random_shape();
        logic [15:0] s [4];
        for (int d = 0; d < 4; d++)
        begin
            case ($urandom_range(4))
                0: s[d] = 16'hFFFF;
                1: s[d] = 16'd0;
                2: s[d] = 16'($urandom_range(1, 9));
                default: s[d] = 16'($urandom);
            endcase
        end
        set_shape(3'($urandom), s[0], s[1], s[2], s[3]);
    endtask

    row_t directed [$];

    function automatic row_t make_row(logic f, logic [63:0] fl, logic [15:0] c0,
                                      logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                                      logic known, miru_pkg::result_t want);
        row_t r;
        r.stim = '{func: f, flat_in: fl, coord_in_0: c0, coord_in_1: c1,
                   coord_in_2: c2, coord_in_3: c3};
        r.known = known;
        r.want = want;
        return r;
    endfunction

    task automatic run_directed(int first, int last);
        miru_pkg::result_t w;
        for (int i = first; i <= last; i++)
        begin
            if (directed[i].known)
            begin
                w = convert_index(directed[i].stim);
                if (w !== directed[i].want)
                    report_mismatch("directed table row", 64'(i), 64'(i));
            end
            send_item(directed[i].stim);
        end
    endtask

    initial
    begin
        shape_dims = 3'd1;
        for (int d = 0; d < 4; d++)
            shape_size[d] = 16'd1;
        // After reset: one dimension of size one.
        directed = {directed, make_row(1'b0, 64'd0, 16'd0, 16'd5, 16'd5, 16'd5, 1'b1, '0)};
        directed = {directed, make_row(1'b0, 64'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b1,
                                       '{flat_out: 64'hFFFF, default: '0})};
        directed = {directed, make_row(1'b1, '1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '0)};
        // Four dimensions of 65535, then zero extents.
        directed = {directed, make_row(1'b0, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                       1'b0, '0)};
        directed = {directed, make_row(1'b0, 64'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '0)};
        directed = {directed, make_row(1'b1, '1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0)};
        directed = {directed, make_row(1'b1, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                       1'b1, '0)};
        directed = {directed, make_row(1'b1, 64'h5555_AAAA_5555_AAAA, 16'd0, 16'd0, 16'd0,
                                       16'd0, 1'b0, '0)};
        directed = {directed, make_row(1'b0, 64'd0, 16'd1, 16'd2, 16'd3, 16'd4, 1'b0, '0)};
        directed = {directed, make_row(1'b1, 64'd123456789, 16'd0, 16'd0, 16'd0, 16'd0,
                                       1'b0, '0)};
        directed = {directed, make_row(1'b0, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                       1'b0, '0)};
        directed = {directed, make_row(1'b1, '1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed(0, 2);
        set_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_directed(3, 5);
        set_shape(3'd7, 16'd0, 16'd7, 16'd0, 16'd3);
        run_directed(6, 8);
        set_shape(3'd0, 16'd1000, 16'd2, 16'd3, 16'd4);
        run_directed(9, 10);
        set_shape(3'd3, 16'd3, 16'd5, 16'd7, 16'd11);
        run_directed(9, 11);
        drain_results();
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0);
        run_directed(9, 11);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 74 : 0;
            for (int n = 0; n < 200; n++)
            begin
                if (n % 40 == 0)
                begin
                    drain_results();
                    repeat (LATENCY) @(posedge clk);
                    random_shape();
                end
                send_item(random_item());
            end
        end

        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
